### design/bfg_pkg.sv
// ----------------------------------------------------------------------------
// bfg_pkg
// Shared widths, constants, charge table and stage beat types for the
// battery fuel gauge filter.
// ----------------------------------------------------------------------------
package bfg_pkg;

  localparam int CODE_W = 8;
  localparam int VOLT_W = 22;
  localparam int UV_W   = 24;
  localparam int PCT_W  = 7;
  localparam int FINE_W = 14;
  localparam int CAP_W  = 22;
  localparam int PROD_W = CAP_W + PCT_W;

  localparam logic REQ_INITIAL  = 1'b0;
  localparam logic REQ_PERIODIC = 1'b1;

  // 3300000 / 255 = 12941 rem 45, and 45 / 255 = 3 / 17
  localparam logic [13:0] UV_PER_CODE = 14'd12941;
  localparam logic [7:0]  RECIP_17    = 8'd241;      // 2^12 / 17, rounded up
  localparam logic [16:0] RECIP_625   = 17'd107375;  // 2^26 / 625, rounded up
  localparam logic [11:0] RECIP_25_S  = 12'd2622;    // 2^16 / 25, rounded up
  localparam logic [27:0] RECIP_25_L  = 28'd171798692; // 2^32 / 25, rounded up

  localparam logic [VOLT_W-1:0] EMPTY_UV = 22'd2000000;
  localparam logic [VOLT_W-1:0] FULL_UV  = 22'd3000000;
  localparam logic [PCT_W-1:0]  PCT_FULL = 7'd100;
  localparam logic [PCT_W-1:0]  LAST_IDX = 7'd99;
  localparam logic [FINE_W-1:0] JUMP_FINE = 14'd2100;   // diff / 100 > 20
  localparam logic [CAP_W-1:0]  RATED_RESET = 22'd11400;

  localparam logic [PCT_W-1:0] LEVEL_TABLE [0:99] = '{
    7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd1,   7'd1,   7'd1,   7'd1,
    7'd1,   7'd2,   7'd2,   7'd2,   7'd3,   7'd3,   7'd3,   7'd4,   7'd4,   7'd5,
    7'd5,   7'd6,   7'd7,   7'd7,   7'd8,   7'd9,   7'd10,  7'd11,  7'd12,  7'd14,
    7'd16,  7'd18,  7'd20,  7'd22,  7'd24,  7'd26,  7'd29,  7'd33,  7'd37,  7'd42,
    7'd47,  7'd51,  7'd55,  7'd59,  7'd63,  7'd67,  7'd71,  7'd75,  7'd78,  7'd80,
    7'd82,  7'd83,  7'd85,  7'd86,  7'd87,  7'd88,  7'd89,  7'd90,  7'd91,  7'd92,
    7'd93,  7'd93,  7'd94,  7'd94,  7'd95,  7'd96,  7'd96,  7'd96,  7'd97,  7'd97,
    7'd98,  7'd98,  7'd99,  7'd99,  7'd99,  7'd100, 7'd100, 7'd100, 7'd100, 7'd100,
    7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100,
    7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100
  };

  typedef struct packed {
    logic              periodic;
    logic              read_error;
    logic [VOLT_W-1:0] volt;
    logic [PCT_W-1:0]  level;
  } volt_beat_t;

  typedef struct packed {
    logic              read_error;
    logic [VOLT_W-1:0] volt;
    logic [FINE_W-1:0] fine;
  } charge_beat_t;

endpackage

### design/bfg_sample_if.sv
// ----------------------------------------------------------------------------
// bfg_sample_if
// Sample channel: one ADC reading per beat.
// ----------------------------------------------------------------------------
interface bfg_sample_if;
  import bfg_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [CODE_W-1:0] adc_code;
  logic              read_error;

  modport source (output valid, req_type, adc_code, read_error, input ready);
  modport sink   (input valid, req_type, adc_code, read_error, output ready);
endinterface

### design/bfg_report_if.sv
// ----------------------------------------------------------------------------
// bfg_report_if
// Report channel: one gauge status per beat.
// ----------------------------------------------------------------------------
interface bfg_report_if;
  import bfg_pkg::*;

  logic              valid;
  logic              ready;
  logic              updated;
  logic [UV_W-1:0]   battery_voltage_uv;
  logic              battery_present;
  logic [PCT_W-1:0]  capacity_percent;
  logic [FINE_W-1:0] capacity_fine;
  logic [CAP_W-1:0]  charge_now;

  modport source (output valid, updated, battery_voltage_uv, battery_present,
                  capacity_percent, capacity_fine, charge_now, input ready);
  modport sink   (input valid, updated, battery_voltage_uv, battery_present,
                  capacity_percent, capacity_fine, charge_now, output ready);
endinterface

### design/battery_fuel_gauge_filter_unit.sv
// ----------------------------------------------------------------------------
// battery_fuel_gauge_filter_unit
// Battery fuel gauge filter: ADC scaling, voltage filter, charge table and
// remaining charge filter, reported once per sample.
//
//   channel   dir  beat contents
//   sample    in   req_type, adc_code, read_error
//   report    out  updated, voltage x3, present, percent, fine, charge_now
//   cfg       in   rated capacity write (cfg_wr_en / cfg_wr_data)
//
// One sample per cycle while the report channel is not stalled.
// Voltage state updates in stage 2, charge state in stage 4.
// Stalls on report back up stage by stage; empty stages still take beats.
// rst is synchronous and clears both filter states and rated capacity to 11400.
// ----------------------------------------------------------------------------
module battery_fuel_gauge_filter_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [bfg_pkg::CAP_W-1:0] cfg_wr_data,
  bfg_sample_if.sink                sample,
  bfg_report_if.source              report
);
  import bfg_pkg::*;

  logic         volt_valid, volt_ready;
  volt_beat_t   volt_beat;
  logic         chg_valid, chg_ready;
  charge_beat_t chg_beat;

  bfg_volt_stage u_volt (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .beat_valid (volt_valid),
    .beat_ready (volt_ready),
    .beat       (volt_beat)
  );

  bfg_charge_stage u_charge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (volt_valid),
    .in_ready  (volt_ready),
    .in_beat   (volt_beat),
    .out_valid (chg_valid),
    .out_ready (chg_ready),
    .out_beat  (chg_beat)
  );

  bfg_report_stage u_report (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (chg_valid),
    .in_ready    (chg_ready),
    .in_beat     (chg_beat),
    .report      (report)
  );

endmodule

### design/bfg_volt_stage.sv
// ----------------------------------------------------------------------------
// bfg_volt_stage
// Scales the ADC code to microvolts, runs the voltage filter and looks up
// the charge level of the filtered voltage. Three register stages.
// ----------------------------------------------------------------------------
module bfg_volt_stage (
  input  logic                clk,
  input  logic                rst,
  bfg_sample_if.sink          sample,
  output logic                beat_valid,
  input  logic                beat_ready,
  output bfg_pkg::volt_beat_t beat
);
  import bfg_pkg::*;

  logic              v1, p1, e1;
  logic [VOLT_W-1:0] smp1;
  logic              v2, p2, e2;
  logic [VOLT_W-1:0] fv2;
  logic [VOLT_W-1:0] fv;
  logic [VOLT_W-1:0] fv_next;

  logic s1_ready, s2_ready, s3_ready;

  logic [VOLT_W-1:0] base_uv;
  logic [9:0]        tri_code;
  logic [17:0]       frac_prod;
  logic [VOLT_W-1:0] sample_uv;

  logic [VOLT_W-1:0] dv;
  logic [32:0]       idx_prod;
  logic [PCT_W-1:0]  idx_raw;
  logic [PCT_W-1:0]  idx;
  logic [PCT_W-1:0]  level;

  assign s3_ready     = !beat_valid || beat_ready;
  assign s2_ready     = !v2 || s3_ready;
  assign s1_ready     = !v1 || s2_ready;
  assign sample.ready = s1_ready;

  assign base_uv   = VOLT_W'(sample.adc_code) * VOLT_W'(UV_PER_CODE);
  assign tri_code  = 10'(sample.adc_code) * 10'd3;
  assign frac_prod = 18'(tri_code) * 18'(RECIP_17);
  assign sample_uv = base_uv + VOLT_W'(frac_prod[17:12]);

  always_comb begin
    if (e1) begin
      fv_next = fv;
    end else if (p1 == REQ_PERIODIC) begin
      fv_next = fv - (fv >> 2) + (smp1 >> 2);
    end else begin
      fv_next = smp1;
    end
  end

  assign dv       = fv2 - EMPTY_UV;
  assign idx_prod = 33'(dv[19:4]) * 33'(RECIP_625);
  assign idx_raw  = idx_prod[32:26];
  assign idx      = (idx_raw > LAST_IDX) ? LAST_IDX : idx_raw;

  always_comb begin
    if (fv2 <= EMPTY_UV) begin
      level = '0;
    end else if (fv2 >= FULL_UV) begin
      level = PCT_FULL;
    end else begin
      level = LEVEL_TABLE[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      beat_valid <= 1'b0;
      fv         <= '0;
    end else begin
      if (s1_ready) begin
        v1 <= sample.valid;
      end
      if (s2_ready) begin
        v2 <= v1;
      end
      if (s3_ready) begin
        beat_valid <= v2;
      end
      if (v1 && s2_ready) begin
        fv <= fv_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && s1_ready) begin
      p1   <= sample.req_type;
      e1   <= sample.read_error;
      smp1 <= sample_uv;
    end
    if (v1 && s2_ready) begin
      p2  <= p1;
      e2  <= e1;
      fv2 <= fv_next;
    end
    if (v2 && s3_ready) begin
      beat.periodic   <= p2;
      beat.read_error <= e2;
      beat.volt       <= fv2;
      beat.level      <= level;
    end
  end

endmodule

### design/bfg_charge_stage.sv
// ----------------------------------------------------------------------------
// bfg_charge_stage
// Remaining charge filter in hundredths of a percent: hold on read error, load, jump or 1/16 IIR.
// ----------------------------------------------------------------------------
module bfg_charge_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bfg_pkg::volt_beat_t   in_beat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bfg_pkg::charge_beat_t out_beat
);
  import bfg_pkg::*;

  logic [FINE_W-1:0] rem;
  logic [FINE_W-1:0] rem_next;
  logic [FINE_W-1:0] target;
  logic [FINE_W-1:0] diff;
  logic [FINE_W-1:0] iir;

  assign in_ready = !out_valid || out_ready;

  assign target = FINE_W'(in_beat.level) * FINE_W'(100);
  assign diff   = (rem > target) ? rem - target : target - rem;
  assign iir    = rem - (rem >> 4) + (target >> 4);

  always_comb begin
    if (in_beat.read_error) begin
      rem_next = rem;
    end else if (in_beat.periodic != REQ_PERIODIC || diff >= JUMP_FINE) begin
      rem_next = target;
    end else begin
      rem_next = iir;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rem       <= '0;
    end else if (in_ready) begin
      out_valid <= in_valid;
      if (in_valid) begin
        rem <= rem_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_beat.read_error <= in_beat.read_error;
      out_beat.volt       <= in_beat.volt;
      out_beat.fine       <= rem_next;
    end
  end

endmodule

### design/bfg_report_stage.sv
// ----------------------------------------------------------------------------
// bfg_report_stage
// Holds the rated capacity and builds the report: whole percent, charge now
// and reported voltage. Three register stages, the last is the output.
// ----------------------------------------------------------------------------
module bfg_report_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [bfg_pkg::CAP_W-1:0] cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bfg_pkg::charge_beat_t in_beat,
  bfg_report_if.source          report
);
  import bfg_pkg::*;

  logic [CAP_W-1:0] rated;

  logic              va, ea;
  logic [VOLT_W-1:0] volta;
  logic [FINE_W-1:0] finea;
  logic [PCT_W-1:0]  pcta;

  logic              vb, eb;
  logic [VOLT_W-1:0] voltb;
  logic [FINE_W-1:0] fineb;
  logic [PCT_W-1:0]  pctb;
  logic [PROD_W-1:0] prodb;

  logic sa_ready, sb_ready, sc_ready;

  logic [23:0]       pct_prod;
  logic [54:0]       chg_prod;

  assign sc_ready = !report.valid || report.ready;
  assign sb_ready = !vb || sc_ready;
  assign sa_ready = !va || sb_ready;
  assign in_ready = sa_ready;

  assign pct_prod = 24'(in_beat.fine[13:2]) * 24'(RECIP_25_S);
  assign chg_prod = 55'(prodb[PROD_W-1:2]) * 55'(RECIP_25_L);

  always_ff @(posedge clk) begin
    if (rst) begin
      rated        <= RATED_RESET;
      va           <= 1'b0;
      vb           <= 1'b0;
      report.valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        rated <= cfg_wr_data;
      end
      if (sa_ready) begin
        va <= in_valid;
      end
      if (sb_ready) begin
        vb <= va;
      end
      if (sc_ready) begin
        report.valid <= vb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && sa_ready) begin
      ea    <= in_beat.read_error;
      volta <= in_beat.volt;
      finea <= in_beat.fine;
      pcta  <= pct_prod[22:16];
    end
    if (va && sb_ready) begin
      eb    <= ea;
      voltb <= volta;
      fineb <= finea;
      pctb  <= pcta;
      prodb <= PROD_W'(rated) * PROD_W'(pcta);
    end
    if (vb && sc_ready) begin
      report.updated            <= !eb;
      report.battery_voltage_uv <= UV_W'(voltb) + (UV_W'(voltb) << 1);
      report.battery_present    <= (voltb != '0);
      report.capacity_percent   <= pctb;
      report.capacity_fine      <= fineb;
      report.charge_now         <= chg_prod[53:32];
    end
  end

endmodule

### design/bfg_checker.sv
// ----------------------------------------------------------------------------
// bfg_checker
// Port-level checks on the gauge report, bound to the top level.
// ----------------------------------------------------------------------------
module bfg_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       rpt_valid,
  input logic                       rpt_ready,
  input logic                       rpt_present,
  input logic [bfg_pkg::UV_W-1:0]   rpt_uv,
  input logic [bfg_pkg::PCT_W-1:0]  rpt_pct,
  input logic [bfg_pkg::FINE_W-1:0] rpt_fine
);
  import bfg_pkg::*;

  logic [FINE_W-1:0] pct_floor;
  assign pct_floor = FINE_W'(rpt_pct) * FINE_W'(100);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rpt_valid && !rpt_ready |=> rpt_valid && $stable(rpt_uv) && $stable(rpt_fine))
    else $error("report beat changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !rpt_valid)
    else $error("report valid after reset");

  a_present: assert property (@(posedge clk) disable iff (rst)
    rpt_valid |-> rpt_present == (rpt_uv != '0))
    else $error("presence does not match voltage");

  a_pct: assert property (@(posedge clk) disable iff (rst)
    rpt_valid |-> rpt_pct <= PCT_FULL && pct_floor <= rpt_fine
                  && rpt_fine < pct_floor + FINE_W'(100))
    else $error("percent does not match fine charge");

endmodule

bind battery_fuel_gauge_filter_unit bfg_checker u_bfg_checker (
  .clk         (clk),
  .rst         (rst),
  .rpt_valid   (report.valid),
  .rpt_ready   (report.ready),
  .rpt_present (report.battery_present),
  .rpt_uv      (report.battery_voltage_uv),
  .rpt_pct     (report.capacity_percent),
  .rpt_fine    (report.capacity_fine)
);

### tb/tb_battery_fuel_gauge_filter_unit.sv
// ----------------------------------------------------------------------------
// tb_battery_fuel_gauge_filter_unit
// Self-checking bench for the fuel gauge filter. Samples are driven through
// the sample channel under random gaps, reports are taken under random
// stalls. A local model tracks the voltage and charge filters and rated
// capacity, and every report beat is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_battery_fuel_gauge_filter_unit;
  import bfg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned DRAIN_CYCLES = 12;

  typedef struct packed {
    logic              updated;
    logic [UV_W-1:0]   battery_voltage_uv;
    logic              battery_present;
    logic [PCT_W-1:0]  capacity_percent;
    logic [FINE_W-1:0] capacity_fine;
    logic [CAP_W-1:0]  charge_now;
  } gauge_report_t;

  localparam int unsigned CHARGE_STEPS [0:99] = '{
      0,   0,   0,   0,   0,   0,   1,   1,   1,   1,
      1,   2,   2,   2,   3,   3,   3,   4,   4,   5,
      5,   6,   7,   7,   8,   9,  10,  11,  12,  14,
     16,  18,  20,  22,  24,  26,  29,  33,  37,  42,
     47,  51,  55,  59,  63,  67,  71,  75,  78,  80,
     82,  83,  85,  86,  87,  88,  89,  90,  91,  92,
     93,  93,  94,  94,  95,  96,  96,  96,  97,  97,
     98,  98,  99,  99,  99, 100, 100, 100, 100, 100,
    100, 100, 100, 100, 100, 100, 100, 100, 100, 100,
    100, 100, 100, 100, 100, 100, 100, 100, 100, 100
  };

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CAP_W-1:0] cfg_wr_data;

  bfg_sample_if sample_ch ();
  bfg_report_if report_ch ();

  battery_fuel_gauge_filter_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sample      (sample_ch),
    .report      (report_ch)
  );

  gauge_report_t report_expect_q [$];
  int unsigned   model_volt_uv;
  int unsigned   model_fine;
  int unsigned   model_rated;
  int unsigned   fail_count;
  int unsigned   cycle_count;
  bit            gaps_on;

  always #5 clk = ~clk;

  function automatic int unsigned charge_for_volt(int unsigned volt);
    if (volt <= 2000000) return 0;
    if (volt >= 3000000) return 100;
    return CHARGE_STEPS[(volt - 2000000) / 10000];
  endfunction

  function automatic gauge_report_t predict_report(logic req, logic [CODE_W-1:0] code,
                                                   logic err);
    gauge_report_t r;
    int unsigned   scaled;
    int unsigned   target;
    int unsigned   diff;
    int unsigned   pct;
    longint unsigned prod;
    if (!err) begin
      scaled = (3300000 * int'(code)) / 255;
      if (req == REQ_INITIAL) begin
        model_volt_uv = scaled;
        model_fine = charge_for_volt(model_volt_uv) * 100;
      end else begin
        model_volt_uv = model_volt_uv - (model_volt_uv >> 2) + (scaled >> 2);
        target = charge_for_volt(model_volt_uv) * 100;
        diff = (model_fine > target) ? model_fine - target : target - model_fine;
        if (diff / 100 > 20) model_fine = target;
        else model_fine = model_fine - (model_fine >> 4) + (target >> 4);
      end
    end
    pct = model_fine / 100;
    prod = longint'(model_rated) * pct;
    r.updated            = !err;
    r.battery_voltage_uv = UV_W'(model_volt_uv * 3);
    r.battery_present    = (model_volt_uv != 0);
    r.capacity_percent   = PCT_W'(pct);
    r.capacity_fine      = FINE_W'(model_fine);
    r.charge_now         = CAP_W'(prod / 100);
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // report side: random stalls, scoreboard compare
  always @(negedge clk) begin
    report_ch.ready = !(gaps_on && ($urandom_range(99) < 6));
  end

  always @(posedge clk) begin
    gauge_report_t exp_r;
    if (!rst && report_ch.valid && report_ch.ready) begin
      if (report_expect_q.size() == 0) begin
        $display("%0t: unexpected report beat, voltage %0d", $time,
                 report_ch.battery_voltage_uv);
        fail_count++;
      end else begin
        exp_r = report_expect_q.pop_front();
        check_field("updated", exp_r.updated, report_ch.updated);
        check_field("battery_voltage_uv", exp_r.battery_voltage_uv,
                    report_ch.battery_voltage_uv);
        check_field("battery_present", exp_r.battery_present, report_ch.battery_present);
        check_field("capacity_percent", exp_r.capacity_percent, report_ch.capacity_percent);
        check_field("capacity_fine", exp_r.capacity_fine, report_ch.capacity_fine);
        check_field("charge_now", exp_r.charge_now, report_ch.charge_now);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d reports outstanding", $time, report_expect_q.size());
      $display("tb_battery_fuel_gauge_filter_unit NOT OK");
      $finish;
    end
  end

  task automatic send_sample(logic req, logic [CODE_W-1:0] code, logic err);
    @(negedge clk);
    if (gaps_on && ($urandom_range(99) < 6)) begin
      sample_ch.valid      = 1'b0;
      sample_ch.req_type   = 1'($urandom_range(1));
      sample_ch.adc_code   = CODE_W'($urandom_range(255));
      sample_ch.read_error = 1'($urandom_range(1));
      @(negedge clk);
    end
    sample_ch.valid      = 1'b1;
    sample_ch.req_type   = req;
    sample_ch.adc_code   = code;
    sample_ch.read_error = err;
    do @(posedge clk); while (!sample_ch.ready);
    report_expect_q.push_back(predict_report(req, code, err));
  endtask

  task automatic drain_reports();
    @(negedge clk);
    sample_ch.valid = 1'b0;
    while (report_expect_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_rated(logic [CAP_W-1:0] value);
    drain_reports();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    cfg_wr_data = CAP_W'($urandom);
    model_rated = value;
  endtask

  task automatic test_reset_state();
    send_sample(REQ_PERIODIC, 8'd200, 1'b1);
    send_sample(REQ_INITIAL, 8'd255, 1'b1);
    send_sample(REQ_PERIODIC, 8'd0, 1'b0);
  endtask

  task automatic test_scale_extremes();
    send_sample(REQ_INITIAL, 8'd0, 1'b0);
    send_sample(REQ_INITIAL, 8'd255, 1'b0);
    send_sample(REQ_PERIODIC, 8'd255, 1'b0);
    send_sample(REQ_PERIODIC, 8'd0, 1'b0);
  endtask

  // codes on either side of the empty and full voltages
  task automatic test_charge_boundaries();
    send_sample(REQ_INITIAL, 8'd154, 1'b0);
    send_sample(REQ_INITIAL, 8'd155, 1'b0);
    send_sample(REQ_INITIAL, 8'd156, 1'b0);
    send_sample(REQ_INITIAL, 8'd231, 1'b0);
    send_sample(REQ_INITIAL, 8'd232, 1'b0);
    send_sample(REQ_INITIAL, 8'd200, 1'b0);
  endtask

  task automatic test_filter_jump();
    send_sample(REQ_INITIAL, 8'd255, 1'b0);
    send_sample(REQ_PERIODIC, 8'd0, 1'b0);
    send_sample(REQ_PERIODIC, 8'd255, 1'b0);
    send_sample(REQ_INITIAL, 8'd190, 1'b0);
    send_sample(REQ_PERIODIC, 8'd192, 1'b0);
    send_sample(REQ_PERIODIC, 8'd188, 1'b0);
  endtask

  task automatic test_read_errors();
    send_sample(REQ_INITIAL, 8'd210, 1'b0);
    send_sample(REQ_PERIODIC, 8'd0, 1'b1);
    send_sample(REQ_INITIAL, 8'd100, 1'b1);
    send_sample(REQ_PERIODIC, 8'd215, 1'b0);
  endtask

  // discharge-like runs: an initial sample then periodic samples drifting
  // around a base code, with sporadic jumps, read errors and missing initials
  task automatic test_random_sequences(int unsigned n_items, logic [CAP_W-1:0] rated);
    int unsigned sent;
    int unsigned run_len;
    int          base;
    int          code;
    write_rated(rated);
    sent = 0;
    while (sent < n_items) begin
      base = ($urandom_range(99) < 70) ? $urandom_range(140, 255) : $urandom_range(255);
      if ($urandom_range(9) != 0) begin
        send_sample(REQ_INITIAL, CODE_W'(base), $urandom_range(99) < 8);
        sent++;
      end
      run_len = $urandom_range(2, 12);
      repeat (run_len) begin
        if ($urandom_range(99) < 15) code = $urandom_range(255);
        else code = base + $urandom_range(16) - 8;
        if (code < 0) code = 0;
        if (code > 255) code = 255;
        send_sample(REQ_PERIODIC, CODE_W'(code), $urandom_range(99) < 8);
        sent++;
      end
    end
  endtask

  task automatic test_pressure_pause();
    send_sample(REQ_INITIAL, 8'd240, 1'b0);
    repeat (8) send_sample(REQ_PERIODIC, CODE_W'($urandom_range(150, 255)), 1'b0);
    drain_reports();
    repeat (8) send_sample(REQ_PERIODIC, CODE_W'($urandom_range(255)),
                           1'($urandom_range(1)));
  endtask

  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    gaps_on     = 1'b1;
    fail_count  = 0;
    cycle_count = 0;
    model_volt_uv = 0;
    model_fine    = 0;
    model_rated   = 11400;
    sample_ch.valid      = 1'b0;
    sample_ch.req_type   = REQ_INITIAL;
    sample_ch.adc_code   = '0;
    sample_ch.read_error = 1'b0;
    report_ch.ready      = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_scale_extremes();
    test_charge_boundaries();
    test_filter_jump();
    test_read_errors();

    test_random_sequences(80, 22'd0);
    test_random_sequences(80, 22'd4000000);
    gaps_on = 1'b0;
    test_random_sequences(80, 22'h3FFFFF);
    gaps_on = 1'b1;
    test_random_sequences(80, CAP_W'($urandom_range(4000000)));
    test_pressure_pause();
    test_random_sequences(80, 22'd11400);

    drain_reports();
    if (fail_count == 0) begin
      $display("tb_battery_fuel_gauge_filter_unit OK");
    end else begin
      $display("tb_battery_fuel_gauge_filter_unit NOT OK");
    end
    $finish;
  end

endmodule

### files.f
design/bfg_pkg.sv
design/bfg_sample_if.sv
design/bfg_report_if.sv
design/bfg_volt_stage.sv
design/bfg_charge_stage.sv
design/bfg_report_stage.sv
design/battery_fuel_gauge_filter_unit.sv
design/bfg_checker.sv
tb/tb_battery_fuel_gauge_filter_unit.sv
